@@ rtl/core/lcs_pkg.sv @@
// Package: shared types and constants for the LED cube animation scanner.
`default_nettype none
package lcs_pkg;

  localparam int unsigned FRAME_BYTES   = 64;
  localparam int unsigned LAYERS        = 8;
  localparam int unsigned FRAME_SEL_W   = 9;
  localparam int unsigned BYTE_SEL_W    = 6;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned COUNT_W       = 10;
  localparam int unsigned SPV_W         = 3;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned FRAME_CAP     = 512;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_STEP    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT    = 1'b0,
    REG_SCANS_PER_VIEW = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = '0;
  localparam logic [SPV_W-1:0]   SPV_RST         = 3'd2;
  localparam logic [SPV_W-1:0]   SPV_MIN         = 3'd1;
  localparam logic [SPV_W-1:0]   SPV_MAX         = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load_byte;
    logic load_tick;
    logic restart;
    logic step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/core/lcs_item_if.sv @@
// Interface: input item channel (valid/ready plus item payload).
`default_nettype none
interface lcs_item_if
  import lcs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [FRAME_SEL_W-1:0] frame_sel;
  logic [BYTE_SEL_W-1:0]  byte_sel;
  logic [VALUE_W-1:0]     write_value;

  modport source (output valid, mode, frame_sel, byte_sel, write_value, input ready);
  modport sink   (input valid, mode, frame_sel, byte_sel, write_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lcs_result_if.sv @@
// Interface: result channel (valid/ready plus one cube layer).
`default_nettype none
interface lcs_result_if
  import lcs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [7:0]             col_byte0;
  logic [7:0]             col_byte1;
  logic [7:0]             col_byte2;
  logic [7:0]             col_byte3;
  logic [7:0]             col_byte4;
  logic [7:0]             col_byte5;
  logic [7:0]             col_byte6;
  logic [7:0]             col_byte7;
  logic [7:0]             ground_select;
  logic [FRAME_SEL_W-1:0] shown_frame;
  logic                   clip_done;

  modport source (output valid, col_byte0, col_byte1, col_byte2, col_byte3, col_byte4,
                  col_byte5, col_byte6, col_byte7, ground_select, shown_frame, clip_done,
                  input ready);
  modport sink   (input valid, col_byte0, col_byte1, col_byte2, col_byte3, col_byte4,
                  col_byte5, col_byte6, col_byte7, ground_select, shown_frame, clip_done,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/lcs_ctrl.sv @@
// Controller: sequences item transfers and scan steps.
`default_nettype none
module lcs_ctrl
  import lcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  input  wire logic [1:0] mode,
  output logic            ready,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  state_t state, state_next;
  logic   xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    xfer       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no transfer while held in reset
        ready = !rst;
        xfer  = valid && ready;
        if (xfer) begin
          unique case (mode_t'(mode))
            MODE_BYTE:    cmd.load_byte = 1'b1;
            MODE_TICK:    cmd.load_tick = 1'b1;
            MODE_RESTART: cmd.restart   = 1'b1;
            MODE_STEP:    state_next    = ST_EXEC;
            default:      state_next    = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        // memory data for the current layer is registered by now
        if (stat.slot_free) begin
          cmd.step   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/lcs_datapath.sv @@
// Datapath: frame and tick stores, config registers, scan counters, result register.
`default_nettype none
module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output stat_t                       stat,
  input  wire logic [FRAME_SEL_W-1:0] frame_sel,
  input  wire logic [BYTE_SEL_W-1:0]  byte_sel,
  input  wire logic [VALUE_W-1:0]     write_value,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  lcs_result_if.source                result
);

  localparam int unsigned STORE_FRAMES = (MAX_FRAMES < FRAME_CAP) ? MAX_FRAMES : FRAME_CAP;
  localparam int unsigned FIDX_W       = $clog2(STORE_FRAMES);
  localparam int unsigned ROWS         = STORE_FRAMES * LAYERS;
  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(STORE_FRAMES);

  // config
  logic [COUNT_W-1:0] frame_count;
  logic [SPV_W-1:0]   scans_per_view;

  // scan state
  logic [FRAME_SEL_W-1:0] current_frame, current_frame_next;
  logic [VALUE_W-1:0]     view_tick, view_tick_next;
  logic [1:0]             scan_pass, scan_pass_next;
  logic [2:0]             layer_index, layer_index_next;

  // stores
  logic [VALUE_W-1:0] tick_mem [STORE_FRAMES];
  logic [VALUE_W-1:0] tick_lo, tick_hi;
  logic [7:0]         lane_rd [LAYERS];

  logic                 wr_ok;
  logic [FIDX_W+2:0]    wr_row, rd_row;
  logic [FIDX_W-1:0]    rd_f0, rd_f1;
  logic [FRAME_SEL_W:0] cf_inc;

  assign wr_ok  = 32'(frame_sel) < MAX_FRAMES;
  assign wr_row = {frame_sel[FIDX_W-1:0], byte_sel[5:3]};
  assign rd_row = {current_frame[FIDX_W-1:0], layer_index};
  assign cf_inc = {1'b0, current_frame} + 1'b1;
  assign rd_f0  = current_frame[FIDX_W-1:0];
  assign rd_f1  = cf_inc[FIDX_W-1:0];

  // one byte lane per column; a layer row reads all eight lanes at once
  for (genvar j = 0; j < LAYERS; j++) begin : g_lane
    logic [7:0] lane_mem [ROWS];
    always_ff @(posedge clk) begin
      if (cmd.load_byte && wr_ok && byte_sel[2:0] == 3'(j)) begin
        lane_mem[wr_row] <= write_value[7:0];
      end
      lane_rd[j] <= lane_mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tick && wr_ok) begin
      tick_mem[frame_sel[FIDX_W-1:0]] <= write_value;
    end
    tick_lo <= tick_mem[rd_f0];
    tick_hi <= tick_mem[rd_f1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= FRAME_COUNT_RST;
      scans_per_view <= SPV_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_COUNT:    frame_count    <= cfg_data[COUNT_W-1:0];
        REG_SCANS_PER_VIEW: scans_per_view <= cfg_data[SPV_W-1:0];
        default:            frame_count    <= frame_count;
      endcase
    end
  end

  // step evaluation
  logic [COUNT_W-1:0] n_frames, n_last;
  logic [COUNT_W-1:0] cf_ext, cf_adv;
  logic [VALUE_W-1:0] dur;
  logic [SPV_W-1:0]   spv, pass_inc;
  logic [VALUE_W:0]   tick_inc;
  logic               emit, last_layer, done;

  assign n_frames = (frame_count > LIMIT) ? LIMIT : frame_count;
  assign n_last   = n_frames - 1'b1;
  assign cf_ext   = {1'b0, current_frame};
  assign cf_adv   = cf_ext + 1'b1;
  assign dur      = tick_hi - tick_lo;
  assign spv      = (scans_per_view < SPV_MIN) ? SPV_MIN :
                    (scans_per_view > SPV_MAX) ? SPV_MAX : scans_per_view;
  assign pass_inc = {1'b0, scan_pass} + 1'b1;
  assign tick_inc = {1'b0, view_tick} + 1'b1;

  always_comb begin
    current_frame_next = current_frame;
    view_tick_next     = view_tick;
    scan_pass_next     = scan_pass;
    layer_index_next   = layer_index;
    emit               = 1'b0;
    last_layer         = 1'b0;
    done               = 1'b0;
    priority if (cmd.restart) begin
      current_frame_next = '0;
      view_tick_next     = '0;
      scan_pass_next     = '0;
      layer_index_next   = '0;
    end else if (cmd.step && n_frames >= COUNT_W'(2)) begin
      view_tick_next   = '0;
      scan_pass_next   = '0;
      layer_index_next = '0;
      priority if (cf_ext >= n_last) begin
        // position past the clip after frame_count was lowered
        current_frame_next = '0;
      end else if (tick_hi <= tick_lo || view_tick >= dur) begin
        current_frame_next = (cf_adv >= n_last) ? '0 : FRAME_SEL_W'(cf_adv);
      end else begin
        emit       = 1'b1;
        last_layer = (layer_index == 3'd7) && (pass_inc >= spv) &&
                     (tick_inc >= {1'b0, dur});
        done       = last_layer && (cf_ext == n_frames - COUNT_W'(2));
        view_tick_next   = view_tick;
        scan_pass_next   = scan_pass;
        layer_index_next = layer_index + 1'b1;
        if (layer_index == 3'd7) begin
          scan_pass_next = pass_inc[1:0];
          if (pass_inc >= spv) begin
            scan_pass_next = '0;
            view_tick_next = tick_inc[VALUE_W-1:0];
            if (tick_inc >= {1'b0, dur}) begin
              view_tick_next     = '0;
              current_frame_next = (cf_adv >= n_last) ? '0 : FRAME_SEL_W'(cf_adv);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_frame <= '0;
      view_tick     <= '0;
      scan_pass     <= '0;
      layer_index   <= '0;
    end else begin
      current_frame <= current_frame_next;
      view_tick     <= view_tick_next;
      scan_pass     <= scan_pass_next;
      layer_index   <= layer_index_next;
    end
  end

  // result register
  assign stat.slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.col_byte0     <= lane_rd[0];
      result.col_byte1     <= lane_rd[1];
      result.col_byte2     <= lane_rd[2];
      result.col_byte3     <= lane_rd[3];
      result.col_byte4     <= lane_rd[4];
      result.col_byte5     <= lane_rd[5];
      result.col_byte6     <= lane_rd[6];
      result.col_byte7     <= lane_rd[7];
      result.ground_select <= 8'b1 << layer_index;
      result.shown_frame   <= current_frame;
      result.clip_done     <= done;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/led_cube_animation_scanner.sv @@
// Top level: LED cube animation scanner, controller plus datapath.
`default_nettype none
// Plays an 8x8x8 LED cube clip out of an on-chip frame store, one cube
// layer per scan step. Item modes: write frame byte (byte = layer*8 +
// column), write a frame's 16-bit start tick, restart at frame 0, and scan
// step. Frame i is shown for start[i+1]-start[i] views; each view scans
// the eight layers scans_per_view times (clamped to 1..4). The last loaded
// frame only bounds its predecessor. A step on an empty or negative
// duration emits nothing and moves on one frame; with fewer than two
// frames a step does nothing. Timing: write and restart transfers are
// taken one per cycle while no scan step is in progress. In a scan step
// the transfer registers the layer row (eight byte lanes) and both start
// ticks from the stores at the current position, and the exec state then
// evaluates and loads the result register. The step holds in the exec
// state while the result register is full and not being taken. Stores
// have no reset and need no clearing pass; reading a never-written entry
// gives garbage. Configuration (cfg_index 0 frame_count, 1 scans_per_view)
// must be written only while the block is idle; the block does not enforce it.
module led_cube_animation_scanner
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lcs_item_if.sink                   item,
  lcs_result_if.source               result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decides what each transfer does and when a step completes
  lcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (item.valid),
    .mode  (item.mode),
    .ready (item.ready),
    .stat  (stat),
    .cmd   (cmd)
  );

  // stores, counters and the result register
  lcs_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .frame_sel   (item.frame_sel),
    .byte_sel    (item.byte_sel),
    .write_value (item.write_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result      (result)
  );

endmodule
`default_nettype wire

@@ verif/led_cube_animation_scanner_test.sv @@
// Self-checking testbench for the LED cube animation scanner: clip playback against a predictor.
`timescale 1ns / 100ps
module led_cube_animation_scanner_test;
  import lcs_pkg::*;

  // Frames whose bytes and start ticks are always written before any scan
  // step. Every frame count used stays within them, except the one long
  // clip phase, which takes only as many steps as keep it inside.
  localparam int unsigned LOADED_FRAMES = 5;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned LONG_HOLD     = 300;   // receiver hold-off, cycles
  localparam int unsigned QUIET_LIMIT   = 3000;  // cycles with no transfer at all

  typedef struct packed {
    mode_t                  mode;
    logic [FRAME_SEL_W-1:0] frame_sel;
    logic [BYTE_SEL_W-1:0]  byte_sel;
    logic [VALUE_W-1:0]     write_value;
  } cube_item_t;

  typedef struct packed {
    logic [7:0][7:0]        cols;     // cols[j] is col_byte j
    logic [7:0]             ground;
    logic [FRAME_SEL_W-1:0] frame;
    logic                   done;
  } cube_layer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       item_valid  = 1'b0;
  cube_item_t item_bits   = '0;
  logic       layer_ready = 1'b0;

  lcs_item_if   item_ch ();
  lcs_result_if result_ch ();

  assign item_ch.valid       = item_valid;
  assign item_ch.mode        = item_bits.mode;
  assign item_ch.frame_sel   = item_bits.frame_sel;
  assign item_ch.byte_sel    = item_bits.byte_sel;
  assign item_ch.write_value = item_bits.write_value;
  assign result_ch.ready     = layer_ready;

  led_cube_animation_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: own copy of the stores, play position and registers
  // ---------------------------------------------------------------------
  bit [7:0]  cube_bytes [0:FRAME_CAP*FRAME_BYTES-1];
  bit [15:0] start_tick [0:FRAME_CAP-1];
  int unsigned shown_idx   = 0;
  int unsigned views_shown = 0;
  int unsigned scan_idx    = 0;
  int unsigned layer_idx   = 0;
  int unsigned clip_frames = 0;   // frame_count register
  int unsigned scans_cfg   = 2;   // scans_per_view register

  cube_layer_t expected_layers [$];
  cube_item_t  pending_items [$];

  int  mismatches   = 0;
  int  send_gap     = 0;
  int  take_gap     = 0;
  int  quiet_cycles = 0;
  bit  no_idle      = 1'b0;  // phase without idle cycles on either side
  bit  hold_go      = 1'b0;
  logic receiver_hold = 1'b0;

  logic [15:0] tick_plan [LOADED_FRAMES];  // last tick queued per loaded frame
  int unsigned random_sent = 0;

  function automatic void rewind();
    shown_idx   = 0;
    views_shown = 0;
    scan_idx    = 0;
    layer_idx   = 0;
  endfunction

  function automatic void next_frame(int unsigned n);
    shown_idx++;
    if (shown_idx >= n - 1) shown_idx = 0;
    views_shown = 0;
    scan_idx    = 0;
    layer_idx   = 0;
  endfunction

  // Works out what one accepted item shows, if anything.
  function automatic void play_item(cube_item_t it);
    int unsigned n, dur, spv;
    cube_layer_t lay;
    bit          last;
    case (it.mode)
      MODE_BYTE: cube_bytes[{it.frame_sel, it.byte_sel}] = it.write_value[7:0];
      MODE_TICK: start_tick[it.frame_sel] = it.write_value;
      MODE_RESTART: rewind();
      default: begin
        n = (clip_frames > FRAME_CAP) ? FRAME_CAP : clip_frames;
        if (n < 2) return;
        // frame count lowered under the play position
        if (shown_idx >= n - 1) begin
          rewind();
          return;
        end
        // empty or negative duration: skip the frame
        if (start_tick[shown_idx + 1] <= start_tick[shown_idx]) begin
          next_frame(n);
          return;
        end
        dur = start_tick[shown_idx + 1] - start_tick[shown_idx];
        // ticks rewritten below the views already shown
        if (views_shown >= dur) begin
          next_frame(n);
          return;
        end
        spv = (scans_cfg == 0) ? 1 : (scans_cfg > 4) ? 4 : scans_cfg;
        for (int j = 0; j < 8; j++)
          lay.cols[j] = cube_bytes[shown_idx * FRAME_BYTES + layer_idx * 8 + j];
        lay.ground = 8'(1 << layer_idx);
        lay.frame  = FRAME_SEL_W'(shown_idx);
        last = (layer_idx == 7) && (scan_idx + 1 >= spv) && (views_shown + 1 >= dur);
        lay.done = last && (shown_idx == n - 2);
        expected_layers = {expected_layers, lay};
        layer_idx++;
        if (layer_idx >= 8) begin
          layer_idx = 0;
          scan_idx++;
          if (scan_idx >= spv) begin
            scan_idx = 0;
            views_shown++;
            if (views_shown >= dur) next_frame(n);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued items, random gap before each one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && item_ch.ready) begin
        play_item(item_bits);
        send_gap = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (!item_valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_bits  <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each layer transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_layers
    cube_layer_t got, want;
    if (rst) begin
      layer_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (result_ch.valid && layer_ready) begin
        got.cols[0] = result_ch.col_byte0;
        got.cols[1] = result_ch.col_byte1;
        got.cols[2] = result_ch.col_byte2;
        got.cols[3] = result_ch.col_byte3;
        got.cols[4] = result_ch.col_byte4;
        got.cols[5] = result_ch.col_byte5;
        got.cols[6] = result_ch.col_byte6;
        got.cols[7] = result_ch.col_byte7;
        got.ground  = result_ch.ground_select;
        got.frame   = result_ch.shown_frame;
        got.done    = result_ch.clip_done;
        if (expected_layers.size() == 0) begin
          mismatches++;
          $display("%0t: layer expected none, got frame %0d ground %02h",
                   $time, got.frame, got.ground);
        end else begin
          want = expected_layers.pop_front();
          for (int j = 0; j < 8; j++)
            if (got.cols[j] !== want.cols[j]) begin
              mismatches++;
              $display("%0t: col_byte%0d expected %02h got %02h",
                       $time, j, want.cols[j], got.cols[j]);
            end
          if (got.ground !== want.ground) begin
            mismatches++;
            $display("%0t: ground_select expected %02h got %02h",
                     $time, want.ground, got.ground);
          end
          if (got.frame !== want.frame) begin
            mismatches++;
            $display("%0t: shown_frame expected %0d got %0d", $time, want.frame, got.frame);
          end
          if (got.done !== want.done) begin
            mismatches++;
            $display("%0t: clip_done expected %0b got %0b", $time, want.done, got.done);
          end
        end
        take_gap = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (take_gap > 0) begin
        take_gap--;
        layer_ready <= 1'b0;
      end else begin
        layer_ready <= !receiver_hold;
      end
    end
  end

  // Long receiver hold-off: the result register fills, the block stalls
  // its input and the driver keeps offering.
  always begin : receiver_hold_off
    wait (hold_go);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    receiver_hold <= 1'b0;
    hold_go = 1'b0;
  end

  // Watchdog: ends the run when nothing transfers for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && item_ch.ready) || (result_ch.valid && layer_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic void queue_item(mode_t m, int unsigned fsel, int unsigned bsel,
                                     int unsigned val);
    cube_item_t it;
    it.mode        = m;
    it.frame_sel   = FRAME_SEL_W'(fsel);
    it.byte_sel    = BYTE_SEL_W'(bsel);
    it.write_value = VALUE_W'(val);
    pending_items = {pending_items, it};
  endfunction

  // step or restart; the unused fields carry noise
  function automatic void queue_blank(mode_t m);
    queue_item(m, $urandom_range(0, 511), $urandom_range(0, 63), $urandom_range(0, 65535));
  endfunction

  function automatic void queue_tick(int unsigned f, int unsigned val);
    if (f < LOADED_FRAMES) tick_plan[f] = VALUE_W'(val);
    queue_item(MODE_TICK, f, $urandom_range(0, 63), val);
  endfunction

  // Mostly scan steps over the loaded clip; ticks kept near-monotonic so
  // frames do advance, with the odd wild value and stray write.
  function automatic void fill_phase(int unsigned count);
    int unsigned pick, f;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        queue_blank(MODE_STEP);
      end else if (pick < 78) begin
        f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                        : $urandom_range(0, LOADED_FRAMES - 1);
        queue_item(MODE_BYTE, f, $urandom_range(0, 63), $urandom_range(0, 65535));
      end else if (pick < 92) begin
        f = $urandom_range(0, LOADED_FRAMES - 1);
        if ($urandom_range(0, 7) == 0)
          queue_tick(f, $urandom_range(0, 65535));
        else if (f == 0)
          queue_tick(f, $urandom_range(0, 3));
        else
          queue_tick(f, tick_plan[f - 1] + $urandom_range(0, 3));
      end else if (pick < 97) begin
        queue_blank(MODE_RESTART);
      end else begin
        queue_tick($urandom_range(LOADED_FRAMES, 511), $urandom_range(0, 65535));
      end
    end
    random_sent += count;
  endfunction

  // Block idle: nothing queued or offered, every layer in, a step that
  // shows nothing given time to finish.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_layers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_COUNT) clip_frames = value & 32'h3FF;
    else scans_cfg = value & 32'h7;
  endtask

  initial begin : stimulus
    logic [7:0]  pix;
    int unsigned phase, fc, spv, steps;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Load the clip: column 0 bytes all clear, column 7 all set, the rest
    // random; top byte of write_value is noise.
    write_register(REG_FRAME_COUNT, 0);
    for (int f = 0; f < LOADED_FRAMES; f++) begin
      for (int b = 0; b < FRAME_BYTES; b++) begin
        case (b % 8)
          0: pix = 8'h00;
          7: pix = 8'hFF;
          default: pix = $urandom_range(0, 255);
        endcase
        queue_item(MODE_BYTE, f, b, {8'($urandom_range(0, 255)), pix});
      end
      queue_tick(f, 2 * f);
    end
    // empty clip, then a single frame: steps show nothing
    queue_blank(MODE_STEP);
    queue_blank(MODE_STEP);
    wait_drained();
    write_register(REG_FRAME_COUNT, 1);
    queue_blank(MODE_STEP);
    wait_drained();

    // Two-frame clip, one scan per view
    write_register(REG_FRAME_COUNT, 2);
    write_register(REG_SCANS_PER_VIEW, 1);
    queue_tick(0, 0);
    queue_tick(1, 16'hFFFF);              // longest duration
    repeat (9) queue_blank(MODE_STEP);    // a full view and one more layer
    queue_tick(1, 1);                     // duration now no longer above views shown
    queue_blank(MODE_STEP);
    queue_tick(1, 0);                     // empty duration
    queue_blank(MODE_STEP);
    queue_tick(1, 1);
    queue_blank(MODE_RESTART);
    repeat (8) queue_blank(MODE_STEP);    // last layer marks the clip done
    queue_blank(MODE_RESTART);

    // Random phases, registers changed between them
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      if (phase == 4) begin
        // Full-size clip: unit durations, one scan per view, and only as
        // many steps as stay inside the loaded frames.
        write_register(REG_FRAME_COUNT, FRAME_CAP);
        write_register(REG_SCANS_PER_VIEW, 1);
        no_idle = 1'b1;
        for (int f = 0; f < LOADED_FRAMES; f++) queue_tick(f, 16'hFFFF - LOADED_FRAMES + 1 + f);
        queue_blank(MODE_RESTART);
        steps = (LOADED_FRAMES - 1) * 8 - 3;
        for (int k = 0; k < steps; k++) begin
          queue_blank(MODE_STEP);
          if (k % 4 == 0)
            queue_item(MODE_BYTE, $urandom_range(LOADED_FRAMES, 511), $urandom_range(0, 63),
                       $urandom_range(0, 65535));
        end
        queue_blank(MODE_RESTART);
        random_sent += LOADED_FRAMES + steps + steps / 4 + 3;
      end else begin
        case ($urandom_range(0, 9))
          0: fc = 0;
          1: fc = 1;
          default: fc = $urandom_range(2, LOADED_FRAMES);
        endcase
        case (phase)
          1: spv = 4;
          3: spv = 0;
          5: spv = 7;
          default: spv = $urandom_range(1, 4);
        endcase
        if (phase == 2) fc = LOADED_FRAMES;
        write_register(REG_FRAME_COUNT, fc);
        write_register(REG_SCANS_PER_VIEW, spv);
        no_idle = ($urandom_range(0, 3) == 0);
        if (phase == 2) begin
          // well-formed clip so layers pile up behind the held receiver
          for (int f = 0; f < LOADED_FRAMES; f++) queue_tick(f, 10 + 2 * f);
          queue_blank(MODE_RESTART);
          hold_go = 1'b1;
        end
        fill_phase($urandom_range(40, 120));
      end
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_layers.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
